// ----- src/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off during reset
`define AGC_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("agc check failed");

// same check with its own message
`define AGC_CHECK_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

// ----- src/agc_pkg.sv -----
`default_nettype none
package agc_pkg;

   // table and word sizing
   localparam int MAX_GROUPS = 256;
   localparam int WORD_LIMIT = 64;
   localparam int ALPHABET   = 26;
   localparam int CNT_W      = $clog2(WORD_LIMIT + 1);
   localparam int GRP_AW     = $clog2(MAX_GROUPS);
   localparam int USED_W     = GRP_AW + 1;
   localparam int SLOT_W     = $clog2(ALPHABET);
   localparam int SIG_W      = ALPHABET * CNT_W;

   // port widths
   localparam int REQ_W      = 8;
   localparam int RSP_W      = 24;
   localparam int IDX_W      = 8;
   localparam int LEN_W      = 7;

   // character codes
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_Z = 8'h5a;
   localparam logic [7:0] CHAR_LO_A = 8'h61;
   localparam logic [7:0] CHAR_LO_Z = 8'h7a;

   typedef logic [ALPHABET-1:0][CNT_W-1:0] sig_type;

   // one closed word handed from front to back
   typedef struct packed {
      sig_type          sig;
      logic [CNT_W-1:0] len;
   } word_rec_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FINISH = 3'b100
   } back_state_type;

endpackage
`default_nettype wire

// ----- src/agc_ram.sv -----
`default_nettype none
module agc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/agc_front.sv -----
`default_nettype none
module agc_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [7:0]             req_tdata,
   input  wire                   req_tlast,
   output logic                  push_valid,
   input  wire                   push_ready,
   output agc_pkg::word_rec_type push_data
);

   agc_pkg::sig_type                counts_ff, counts_in;
   logic [agc_pkg::CNT_W-1:0]       kept_ff, kept_in;
   logic                            accept;
   logic                            is_upper, is_lower, is_letter;
   logic [agc_pkg::SLOT_W-1:0]      slot;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   // letter decode
   always_comb begin
      is_upper  = (req_tdata >= agc_pkg::CHAR_UP_A) && (req_tdata <= agc_pkg::CHAR_UP_Z);
      is_lower  = (req_tdata >= agc_pkg::CHAR_LO_A) && (req_tdata <= agc_pkg::CHAR_LO_Z);
      is_letter = is_upper || is_lower;
      if (is_upper) begin
         slot = agc_pkg::SLOT_W'(req_tdata - agc_pkg::CHAR_UP_A);
      end else begin
         slot = agc_pkg::SLOT_W'(req_tdata - agc_pkg::CHAR_LO_A);
      end
   end

   // histogram update and word close
   always_comb begin
      counts_in  = counts_ff;
      kept_in    = kept_ff;
      push_valid = 1'b0;
      push_data  = '0;
      if (accept) begin
         if (is_letter && (kept_ff < agc_pkg::CNT_W'(agc_pkg::WORD_LIMIT))) begin
            for (int i = 0; i < agc_pkg::ALPHABET; i++) begin
               if (slot == agc_pkg::SLOT_W'(i)) begin
                  counts_in[i] = counts_ff[i] + 1'b1;
               end
            end
            kept_in = kept_ff + 1'b1;
         end
         if (!is_letter || req_tlast) begin
            push_data.sig = counts_in;
            push_data.len = kept_in;
            push_valid    = (kept_in != '0);
            counts_in     = '0;
            kept_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
         kept_ff   <= '0;
      end else begin
         counts_ff <= counts_in;
         kept_ff   <= kept_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/agc_queue.sv -----
`default_nettype none
module agc_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  agc_pkg::word_rec_type in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output agc_pkg::word_rec_type out_data
);

   agc_pkg::word_rec_type ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/agc_back.sv -----
`default_nettype none
module agc_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   pop_valid,
   output logic                  pop_ready,
   input  agc_pkg::word_rec_type pop_data,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [agc_pkg::RSP_W-1:0] rsp_tdata
);

   agc_pkg::back_state_type         state_ff, state_in;
   agc_pkg::word_rec_type           word_ff, word_in;
   logic [agc_pkg::USED_W-1:0]      addr_ff, addr_in;
   logic [agc_pkg::USED_W-1:0]      used_ff, used_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [agc_pkg::GRP_AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [agc_pkg::GRP_AW-1:0]      res_idx_ff, res_idx_in;
   logic                            res_new_ff, res_new_in;
   logic                            res_full_ff, res_full_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [agc_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                            ram_wen, ram_ren;
   logic [agc_pkg::GRP_AW-1:0]      ram_waddr, ram_raddr;
   logic [agc_pkg::SIG_W-1:0]       ram_rdata;

   // one row of letter counts per group
   agc_ram #(
      .WIDTH (agc_pkg::SIG_W),
      .DEPTH (agc_pkg::MAX_GROUPS)
   ) u_sig_ram (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (word_ff.sig),
      .rd_en   (ram_ren),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pop_ready  = (state_ff == agc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // search sequencer: one row read issued per cycle, compared in the cycle after
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      addr_in      = addr_ff;
      used_in      = used_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      res_idx_in   = res_idx_ff;
      res_new_in   = res_new_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wen      = 1'b0;
      ram_ren      = 1'b0;
      ram_waddr    = used_ff[agc_pkg::GRP_AW-1:0];
      ram_raddr    = addr_ff[agc_pkg::GRP_AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         agc_pkg::ST_IDLE: begin
            if (pop_valid) begin
               word_in    = pop_data;
               addr_in    = '0;
               cmp_vld_in = 1'b0;
               state_in   = agc_pkg::ST_SEARCH;
            end
         end
         agc_pkg::ST_SEARCH: begin
            if (cmp_vld_ff && (ram_rdata == word_ff.sig)) begin
               res_idx_in  = cmp_idx_ff;
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               state_in    = agc_pkg::ST_FINISH;
            end else if (addr_ff < used_ff) begin
               ram_ren    = 1'b1;
               cmp_idx_in = addr_ff[agc_pkg::GRP_AW-1:0];
               cmp_vld_in = 1'b1;
               addr_in    = addr_ff + 1'b1;
            end else if (used_ff < agc_pkg::USED_W'(agc_pkg::MAX_GROUPS)) begin
               // no match: open a new group
               ram_wen     = 1'b1;
               res_idx_in  = used_ff[agc_pkg::GRP_AW-1:0];
               res_new_in  = 1'b1;
               res_full_in = 1'b0;
               used_in     = used_ff + 1'b1;
               state_in    = agc_pkg::ST_FINISH;
            end else begin
               res_idx_in  = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
               state_in    = agc_pkg::ST_FINISH;
            end
         end
         agc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, agc_pkg::LEN_W'(word_ff.len), res_full_ff,
                               res_new_ff, agc_pkg::IDX_W'(res_idx_ff)};
               state_in     = agc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = agc_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agc_pkg::ST_IDLE;
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      addr_ff     <= addr_in;
      cmp_idx_ff  <= cmp_idx_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- src/anagram_group_classifier_unit.sv -----
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata byte_req, req_tlast stream_end
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata group_index, fresh_group, table_full, word_length
//
// a letter or separator byte is taken whenever the word queue has room
// a closing word is looked up in the back end: one group row is read per cycle
// from the signature ram and compared, then the result is loaded
// the two-entry word queue lets bytes keep flowing during a search
// reset is synchronous; it clears the histogram, the group count and all valids
// a stalled rsp holds the back end in its finish state; a full queue drops req_tready
`default_nettype none
module anagram_group_classifier_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,   // [7:0] byte_req
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] group_index, [8] fresh_group,
                                    // [9] table_full, [16:10] word_length, [23:17] zero
);

   logic                  push_valid, push_ready;
   agc_pkg::word_rec_type push_data;
   logic                  pop_valid, pop_ready;
   agc_pkg::word_rec_type pop_data;

   // byte intake and histogram
   agc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // closed words waiting for lookup
   agc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // group table search and result
   agc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- src/agc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module agc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata
);

   // a waiting result stays offered
   `AGC_CHECK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // new group and full table never together
   `AGC_CHECK(a_new_not_full, clock, reset, rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))

   // a full table reports group zero
   `AGC_CHECK(a_full_index, clock, reset, rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[7:0] == 8'd0)

   // only non-empty words give a result
   `AGC_CHECK_MSG(a_len_nonzero, clock, reset, rsp_tvalid |-> rsp_tdata[16:10] != 7'd0, "empty")

endmodule

bind anagram_group_classifier_unit agc_checker u_agc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
